[rtl/rfd_pkg.sv]
// ----------------------------------------------------------------------------
// rfd_pkg
// shared constants and types for the remote frame decoder
// ----------------------------------------------------------------------------
package rfd_pkg;

  localparam int FRAME_BYTES      = 18;
  localparam int BUFFER_BYTES_DEF = 36;
  localparam int FRAME_IDX_W      = $clog2(FRAME_BYTES);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STICK_LIMIT    = 2'd1;

  localparam logic [CFG_DATA_W-1:0] CHANNEL_OFFSET_RST = 11'd1024;
  localparam logic [CFG_DATA_W-1:0] STICK_LIMIT_RST    = 11'd700;

  localparam logic [1:0] SW_DOWN = 2'd2;
  localparam logic [1:0] SW_NONE = 2'd0;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_IDLE = 1'b1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic signed [11:0] stick_0;
    logic signed [11:0] stick_1;
    logic signed [11:0] stick_2;
    logic signed [11:0] stick_3;
    logic signed [15:0] wheel_channel;
    logic [3:0]         switches;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [15:0]        mouse_buttons;
    logic [15:0]        key_bits;
    logic               frame_error;
  } rfd_result_t;

endpackage

[rtl/rfd_decode.sv]
// ----------------------------------------------------------------------------
// rfd_decode
// unpacks a stored frame, removes the channel offset and applies the
// validity check
// ----------------------------------------------------------------------------
module rfd_decode (
  input  rfd_pkg::byte_t                      frame [rfd_pkg::FRAME_BYTES],
  input  logic [rfd_pkg::CFG_DATA_W-1:0]      channel_offset,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]      stick_limit,
  output rfd_pkg::rfd_result_t                result
);

  logic [10:0]        raw [4];
  logic signed [11:0] st [4];
  logic [11:0]        mag [4];
  logic [3:0]         over;
  logic [1:0]         sw_l;
  logic [1:0]         sw_r;
  logic [15:0]        wheel_raw;
  logic               err;

  assign raw[0] = {frame[1][2:0], frame[0]};
  assign raw[1] = {frame[2][5:0], frame[1][7:3]};
  assign raw[2] = {frame[4][0], frame[3], frame[2][7:6]};
  assign raw[3] = {frame[5][3:0], frame[4][7:1]};
  assign sw_l   = frame[5][5:4];
  assign sw_r   = frame[5][7:6];
  assign wheel_raw = {frame[17], frame[16]};

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      st[k]   = $signed({1'b0, raw[k]}) - $signed({1'b0, channel_offset});
      mag[k]  = st[k][11] ? 12'(-st[k]) : 12'(st[k]);
      over[k] = mag[k] > {1'b0, stick_limit};
    end
  end

  assign err = (|over) || (sw_l == rfd_pkg::SW_NONE) || (sw_r == rfd_pkg::SW_NONE);

  always_comb begin
    if (err) begin
      result             = '0;
      result.switches    = {rfd_pkg::SW_DOWN, rfd_pkg::SW_DOWN};
      result.frame_error = 1'b1;
    end else begin
      result.stick_0       = st[0];
      result.stick_1       = st[1];
      result.stick_2       = st[2];
      result.stick_3       = st[3];
      result.wheel_channel = wheel_raw - {5'b0, channel_offset};
      result.switches      = {sw_r, sw_l};
      result.mouse_x       = {frame[7], frame[6]};
      result.mouse_y       = {frame[9], frame[8]};
      result.mouse_z       = {frame[11], frame[10]};
      result.mouse_buttons = {frame[13], frame[12]};
      result.key_bits      = {frame[15], frame[14]};
      result.frame_error   = 1'b0;
    end
  end

endmodule

[rtl/remote_frame_decoder.sv]
// ----------------------------------------------------------------------------
// remote_frame_decoder
// result: registered on the idle transaction, via the skid entry if stalled
// throughput: one transaction per cycle while in_ready, bytes and idle alike
// a two-entry output buffer keeps in_ready high while one result is stalled
// reset: byte count and output buffer cleared, config preset, frame store not
// ----------------------------------------------------------------------------
module remote_frame_decoder #(
  parameter int BUFFER_BYTES = rfd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [11:0]               out_stick_0,
  output logic signed [11:0]               out_stick_1,
  output logic signed [11:0]               out_stick_2,
  output logic signed [11:0]               out_stick_3,
  output logic signed [15:0]               out_wheel_channel,
  output logic [3:0]                       out_switches,
  output logic signed [15:0]               out_mouse_x,
  output logic signed [15:0]               out_mouse_y,
  output logic signed [15:0]               out_mouse_z,
  output logic [15:0]                      out_mouse_buttons,
  output logic [15:0]                      out_key_bits,
  output logic                             out_frame_error,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rfd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

  logic [CNT_W-1:0]                    count_r, count_nxt;
  rfd_pkg::byte_t                      store_r [rfd_pkg::FRAME_BYTES];
  logic [rfd_pkg::CFG_DATA_W-1:0]      offset_r;
  logic [rfd_pkg::CFG_DATA_W-1:0]      limit_r;
  rfd_pkg::rfd_result_t                dec_result;
  rfd_pkg::rfd_result_t                out_data_r, skid_data_r;
  logic                                out_valid_r, skid_valid_r;
  logic                                in_fire, emit, out_take, out_free;

  assign in_ready  = !skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign emit      = in_fire && (in_req_type == rfd_pkg::REQ_IDLE) &&
                     (count_r == CNT_W'(rfd_pkg::FRAME_BYTES));
  assign out_take  = out_valid_r && out_ready;
  assign out_free  = !out_valid_r || out_take;

  always_comb begin
    count_nxt = count_r;
    if (in_fire) begin
      if (in_req_type == rfd_pkg::REQ_IDLE) begin
        count_nxt = '0;
      end else if (count_r < CNT_W'(BUFFER_BYTES)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      offset_r <= rfd_pkg::CHANNEL_OFFSET_RST;
      limit_r  <= rfd_pkg::STICK_LIMIT_RST;
    end else begin
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rfd_pkg::CFG_CHANNEL_OFFSET: offset_r <= cfg_wdata;
          rfd_pkg::CFG_STICK_LIMIT:    limit_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_req_type == rfd_pkg::REQ_DATA) &&
        (count_r < CNT_W'(rfd_pkg::FRAME_BYTES))) begin
      store_r[count_r[rfd_pkg::FRAME_IDX_W-1:0]] <= in_rx_byte;
    end
  end

  rfd_decode u_decode (
    .frame          (store_r),
    .channel_offset (offset_r),
    .stick_limit    (limit_r),
    .result         (dec_result)
  );

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= emit;
      end else begin
        out_valid_r  <= emit;
        skid_valid_r <= 1'b0;
      end
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
        if (emit) begin
          skid_data_r <= dec_result;
        end
      end else if (emit) begin
        out_data_r <= dec_result;
      end
    end else if (emit) begin
      skid_data_r <= dec_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_stick_0       = out_data_r.stick_0;
  assign out_stick_1       = out_data_r.stick_1;
  assign out_stick_2       = out_data_r.stick_2;
  assign out_stick_3       = out_data_r.stick_3;
  assign out_wheel_channel = out_data_r.wheel_channel;
  assign out_switches      = out_data_r.switches;
  assign out_mouse_x       = out_data_r.mouse_x;
  assign out_mouse_y       = out_data_r.mouse_y;
  assign out_mouse_z       = out_data_r.mouse_z;
  assign out_mouse_buttons = out_data_r.mouse_buttons;
  assign out_key_bits      = out_data_r.key_bits;
  assign out_frame_error   = out_data_r.frame_error;

endmodule

[rtl/rfd_checker.sv]
// ----------------------------------------------------------------------------
// rfd_checker
// port-level checks for the remote frame decoder, bound to the top level
// ----------------------------------------------------------------------------
module rfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_req_type,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [11:0] out_stick_0,
  input logic [3:0]         out_switches,
  input logic signed [15:0] out_mouse_x,
  input logic [15:0]        out_key_bits,
  input logic               out_frame_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stick_0) &&
    $stable(out_switches) && $stable(out_frame_error))
    else $error("stalled result changed");

  a_rise_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready &&
                               (in_req_type == rfd_pkg::REQ_IDLE)))
    else $error("result without idle transaction");

  a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_error |->
    out_switches == {rfd_pkg::SW_DOWN, rfd_pkg::SW_DOWN} && out_stick_0 == 12'sd0 &&
    out_mouse_x == 16'sd0 && out_key_bits == 16'd0)
    else $error("rejected frame not cleared");

  a_good_switches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_error |-> out_switches[1:0] != rfd_pkg::SW_NONE &&
    out_switches[3:2] != rfd_pkg::SW_NONE)
    else $error("accepted frame with switch at zero");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind remote_frame_decoder rfd_checker u_rfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_req_type     (in_req_type),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_stick_0     (out_stick_0),
  .out_switches    (out_switches),
  .out_mouse_x     (out_mouse_x),
  .out_key_bits    (out_key_bits),
  .out_frame_error (out_frame_error)
);

[tb/remote_frame_decoder_tb.sv]
// ----------------------------------------------------------------------------
// remote_frame_decoder_tb
// self-checking testbench for the remote frame decoder
// a table of directed bursts, then random bursts over several register
// settings, with random gaps and stalls on both channels; every decoded
// frame is checked field by field against an in-bench frame decoder
// ----------------------------------------------------------------------------
module remote_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUFFER_BYTES  = rfd_pkg::BUFFER_BYTES_DEF;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 10;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 55;

  localparam logic [rfd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [rfd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef logic [rfd_pkg::FRAME_BYTES*8-1:0] frame_t;

  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_NONE,
    EXP_REJECT
  } exp_kind_t;

  typedef struct packed {
    logic [10:0] offset;
    logic [10:0] limit;
    logic [5:0]  n_bytes;
    logic [10:0] ch0;
    logic [10:0] ch1;
    logic [10:0] ch2;
    logic [10:0] ch3;
    logic [1:0]  sw_l;
    logic [1:0]  sw_r;
    logic [15:0] mx;
    logic [15:0] my;
    logic [15:0] mz;
    logic [15:0] buttons;
    logic [15:0] keys;
    logic [15:0] wheel;
    exp_kind_t   kind;
  } burst_row_t;

  localparam rfd_pkg::rfd_result_t REJECT_RESULT = '{
    switches:    {rfd_pkg::SW_DOWN, rfd_pkg::SW_DOWN},
    frame_error: 1'b1,
    default:     '0
  };

  localparam int N_DIRECTED = 18;
  localparam burst_row_t DIRECTED_BURSTS [N_DIRECTED] = '{
    // all zero after reset, switches off
    '{11'd1024, 11'd700, 6'd18, 11'd0, 11'd0, 11'd0, 11'd0, 2'd0, 2'd0,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, EXP_REJECT},
    // all ones, sticks out of range
    '{11'd1024, 11'd700, 6'd18, 11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff, 2'd3, 2'd3,
      16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, EXP_REJECT},
    '{11'd1024, 11'd700, 6'd18, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd3,
      16'h8000, 16'h7fff, 16'h0001, 16'h0100, 16'ha55a, 16'h0400, EXP_PREDICT},
    // magnitude exactly at the limit
    '{11'd1024, 11'd700, 6'd18, 11'd1724, 11'd324, 11'd1024, 11'd1724, 2'd2, 2'd2,
      16'h1234, 16'hfedc, 16'h0080, 16'h01ff, 16'h8001, 16'hffff, EXP_PREDICT},
    '{11'd1024, 11'd700, 6'd18, 11'd1024, 11'd323, 11'd1024, 11'd1024, 2'd1, 2'd1,
      16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666, EXP_REJECT},
    '{11'd1024, 11'd700, 6'd18, 11'd1024, 11'd1024, 11'd1024, 11'd1725, 2'd1, 2'd1,
      16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666, EXP_REJECT},
    '{11'd1024, 11'd700, 6'd18, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd0, 2'd2,
      16'h0102, 16'h0304, 16'h0506, 16'h0708, 16'h090a, 16'h0b0c, EXP_REJECT},
    '{11'd1024, 11'd700, 6'd18, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd3, 2'd0,
      16'h0102, 16'h0304, 16'h0506, 16'h0708, 16'h090a, 16'h0b0c, EXP_REJECT},
    // wrong lengths, including count saturation
    '{11'd1024, 11'd700, 6'd17, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd1,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, EXP_NONE},
    '{11'd1024, 11'd700, 6'd19, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd1,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, EXP_NONE},
    '{11'd1024, 11'd700, 6'd0, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd1,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, EXP_NONE},
    '{11'd1024, 11'd700, 6'd40, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 2'd1, 2'd1,
      16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, EXP_NONE},
    '{11'd1024, 11'd700, 6'd18, 11'd1500, 11'd600, 11'd1023, 11'd1025, 2'd2, 2'd1,
      16'hff00, 16'h00ff, 16'h7f80, 16'h0001, 16'hffff, 16'h0000, EXP_PREDICT},
    // register extremes
    '{11'd0, 11'd2047, 6'd18, 11'd0, 11'h7ff, 11'd0, 11'h7ff, 2'd1, 2'd2,
      16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'h0000, 16'h0000, EXP_PREDICT},
    '{11'd2047, 11'd2047, 6'd18, 11'd0, 11'h7ff, 11'd0, 11'd1, 2'd3, 2'd1,
      16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'hffff, 16'h0000, EXP_PREDICT},
    '{11'd0, 11'd0, 6'd18, 11'd0, 11'd0, 11'd0, 11'd0, 2'd1, 2'd1,
      16'h0001, 16'hfffe, 16'h4000, 16'h0101, 16'h8000, 16'hffff, EXP_PREDICT},
    '{11'd2047, 11'd0, 6'd18, 11'h7ff, 11'h7ff, 11'h7ff, 11'h7ff, 2'd2, 2'd3,
      16'h00ff, 16'hff00, 16'h0f0f, 16'h0100, 16'h0001, 16'h07ff, EXP_PREDICT},
    '{11'd2047, 11'd0, 6'd18, 11'h7fe, 11'h7ff, 11'h7ff, 11'h7ff, 2'd2, 2'd3,
      16'h00ff, 16'hff00, 16'h0f0f, 16'h0100, 16'h0001, 16'h07ff, EXP_REJECT}
  };

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_req_type;
  logic [7:0]                     in_rx_byte;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [11:0]             out_stick_0;
  logic signed [11:0]             out_stick_1;
  logic signed [11:0]             out_stick_2;
  logic signed [11:0]             out_stick_3;
  logic signed [15:0]             out_wheel_channel;
  logic [3:0]                     out_switches;
  logic signed [15:0]             out_mouse_x;
  logic signed [15:0]             out_mouse_y;
  logic signed [15:0]             out_mouse_z;
  logic [15:0]                    out_mouse_buttons;
  logic [15:0]                    out_key_bits;
  logic                           out_frame_error;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rfd_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // decoder state mirrored in the bench
  logic [10:0]    cur_offset;
  logic [10:0]    cur_limit;
  rfd_pkg::byte_t frame_mem [rfd_pkg::FRAME_BYTES];
  int             byte_cnt;

  rfd_pkg::rfd_result_t frame_q [$];
  int                   mismatch_cnt;
  int                   items_sent;
  int                   cycle_cnt;
  bit                   tx_gaps;
  bit                   rx_stalls;

  remote_frame_decoder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_stick_0       (out_stick_0),
    .out_stick_1       (out_stick_1),
    .out_stick_2       (out_stick_2),
    .out_stick_3       (out_stick_3),
    .out_wheel_channel (out_wheel_channel),
    .out_switches      (out_switches),
    .out_mouse_x       (out_mouse_x),
    .out_mouse_y       (out_mouse_y),
    .out_mouse_z       (out_mouse_z),
    .out_mouse_buttons (out_mouse_buttons),
    .out_key_bits      (out_key_bits),
    .out_frame_error   (out_frame_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic frame_t build_frame(
    input logic [10:0] c0, c1, c2, c3,
    input logic [1:0]  sl, sr,
    input logic [15:0] mx, my, mz, btn, keys, wheel
  );
    return {wheel, keys, btn, mz, my, mx, sr, sl, c3, c2, c1, c0};
  endfunction

  // updates the mirrored state, returns 1 when the event yields a decoded frame
  function automatic bit decode_event(input logic req, input rfd_pkg::byte_t data,
                                      output rfd_pkg::rfd_result_t res);
    logic [47:0] rc_bits;
    logic [10:0] raw [4];
    logic [11:0] stick [4];
    int          diff;
    bit          bad;
    res = '0;
    bad = 1'b0;
    if (req == rfd_pkg::REQ_DATA) begin
      if (byte_cnt < rfd_pkg::FRAME_BYTES) frame_mem[byte_cnt] = data;
      if (byte_cnt < BUFFER_BYTES) byte_cnt++;
      return 1'b0;
    end
    if (byte_cnt != rfd_pkg::FRAME_BYTES) begin
      byte_cnt = 0;
      return 1'b0;
    end
    byte_cnt = 0;
    for (int k = 0; k < 6; k++) rc_bits[k*8 +: 8] = frame_mem[k];
    for (int k = 0; k < 4; k++) begin
      raw[k] = rc_bits[k*11 +: 11];
      diff = int'(raw[k]) - int'(cur_offset);
      stick[k] = 12'(diff);
      if ((diff < 0 ? -diff : diff) > int'(cur_limit)) bad = 1'b1;
    end
    if (rc_bits[45:44] == rfd_pkg::SW_NONE || rc_bits[47:46] == rfd_pkg::SW_NONE)
      bad = 1'b1;
    if (bad) begin
      res = REJECT_RESULT;
      return 1'b1;
    end
    res.stick_0       = stick[0];
    res.stick_1       = stick[1];
    res.stick_2       = stick[2];
    res.stick_3       = stick[3];
    res.wheel_channel = {frame_mem[17], frame_mem[16]} - {5'd0, cur_offset};
    res.switches      = rc_bits[47:44];
    res.mouse_x       = {frame_mem[7], frame_mem[6]};
    res.mouse_y       = {frame_mem[9], frame_mem[8]};
    res.mouse_z       = {frame_mem[11], frame_mem[10]};
    res.mouse_buttons = {frame_mem[13], frame_mem[12]};
    res.key_bits      = {frame_mem[15], frame_mem[14]};
    res.frame_error   = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [10:0] rand_channel();
    int lo;
    int hi;
    if ($urandom_range(0, 11) == 0) return 11'($urandom_range(0, 2047));
    lo = int'(cur_offset) - int'(cur_limit);
    hi = int'(cur_offset) + int'(cur_limit);
    if (lo < 0) lo = 0;
    if (hi > 2047) hi = 2047;
    return 11'($urandom_range(lo, hi));
  endfunction

  function automatic logic [1:0] rand_switch();
    if ($urandom_range(0, 9) == 0) return 2'($urandom_range(0, 3));
    return 2'($urandom_range(1, 3));
  endfunction

  task automatic send_event(input logic req, input rfd_pkg::byte_t data,
                            output bit got, output rfd_pkg::rfd_result_t res);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_rx_byte  <= data;
    do @(posedge clk); while (in_ready !== 1'b1);
    got = decode_event(req, data, res);
    items_sent++;
  endtask

  task automatic send_burst(input frame_t frm, input int n_bytes, input exp_kind_t kind);
    bit                   got;
    rfd_pkg::rfd_result_t res;
    for (int i = 0; i < n_bytes; i++) begin
      send_event(rfd_pkg::REQ_DATA,
                 (i < rfd_pkg::FRAME_BYTES) ? frm[i*8 +: 8] : rfd_pkg::byte_t'($urandom),
                 got, res);
    end
    send_event(rfd_pkg::REQ_IDLE, rfd_pkg::byte_t'($urandom), got, res);
    case (kind)
      EXP_PREDICT: if (got) frame_q.push_back(res);
      EXP_REJECT:  frame_q.push_back(REJECT_RESULT);
      default:     ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rfd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == rfd_pkg::CFG_CHANNEL_OFFSET) cur_offset = val;
    else if (idx == rfd_pkg::CFG_STICK_LIMIT) cur_limit = val;
  endtask

  task automatic apply_settings(input logic [10:0] offset, input logic [10:0] limit,
                                input bit spare);
    wait_drained();
    if (spare) write_reg(CFG_SPARE_A, rfd_pkg::CFG_DATA_W'($urandom));
    write_reg(rfd_pkg::CFG_CHANNEL_OFFSET, offset);
    write_reg(rfd_pkg::CFG_STICK_LIMIT, limit);
    if (spare) write_reg(CFG_SPARE_B, rfd_pkg::CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // receiver: random stall before each result
  initial begin
    int stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_stalls ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // result checker
  always @(posedge clk) begin
    rfd_pkg::rfd_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (frame_q.size() == 0) begin
        $display("%0t unexpected result transaction", $time);
        mismatch_cnt++;
      end else begin
        want = frame_q.pop_front();
        compare_field("stick_0", 16'(want.stick_0), 16'(out_stick_0));
        compare_field("stick_1", 16'(want.stick_1), 16'(out_stick_1));
        compare_field("stick_2", 16'(want.stick_2), 16'(out_stick_2));
        compare_field("stick_3", 16'(want.stick_3), 16'(out_stick_3));
        compare_field("wheel_channel", want.wheel_channel, out_wheel_channel);
        compare_field("switches", 16'(want.switches), 16'(out_switches));
        compare_field("mouse_x", want.mouse_x, out_mouse_x);
        compare_field("mouse_y", want.mouse_y, out_mouse_y);
        compare_field("mouse_z", want.mouse_z, out_mouse_z);
        compare_field("mouse_buttons", want.mouse_buttons, out_mouse_buttons);
        compare_field("key_bits", want.key_bits, out_key_bits);
        compare_field("frame_error", 16'(want.frame_error), 16'(out_frame_error));
      end
    end
  end

  // watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[remote_frame_decoder] ERROR");
    $finish;
  end

  initial begin
    burst_row_t  row;
    frame_t      frm;
    int          n_bytes;
    int          pick;
    int          phase_end;
    logic [10:0] offset;
    logic [10:0] limit;
    exp_kind_t   kind;

    mismatch_cnt = 0;
    items_sent   = 0;
    byte_cnt     = 0;
    cur_offset   = rfd_pkg::CHANNEL_OFFSET_RST;
    cur_limit    = rfd_pkg::STICK_LIMIT_RST;
    tx_gaps      = 1'b1;
    rx_stalls    = 1'b1;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= rfd_pkg::REQ_DATA;
    in_rx_byte  <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= rfd_pkg::CFG_CHANNEL_OFFSET;
    cfg_wdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      row = DIRECTED_BURSTS[r];
      if (row.offset != cur_offset || row.limit != cur_limit)
        apply_settings(row.offset, row.limit, r == N_DIRECTED - 1);
      frm = build_frame(row.ch0, row.ch1, row.ch2, row.ch3, row.sw_l, row.sw_r,
                        row.mx, row.my, row.mz, row.buttons, row.keys, row.wheel);
      send_burst(frm, int'(row.n_bytes), row.kind);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       offset = 11'd0;
        1:       offset = 11'd2047;
        default: offset = 11'($urandom_range(0, 2047));
      endcase
      case ($urandom_range(0, 3))
        0:       limit = 11'd0;
        1:       limit = 11'd2047;
        default: limit = 11'($urandom_range(0, 2047));
      endcase
      apply_settings(offset, limit, 1'b1);
      tx_gaps   = (p != 1 && p != 3);
      rx_stalls = (p != 1 && p != 4);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        frm = build_frame(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
                          rand_switch(), rand_switch(),
                          16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
        pick = $urandom_range(0, 9);
        if (pick < 7) n_bytes = rfd_pkg::FRAME_BYTES;
        else if (pick == 7) n_bytes = $urandom_range(0, rfd_pkg::FRAME_BYTES - 1);
        else if (pick == 8)
          n_bytes = $urandom_range(rfd_pkg::FRAME_BYTES + 1, BUFFER_BYTES + 9);
        else n_bytes = 0;
        kind = EXP_PREDICT;
        send_burst(frm, n_bytes, kind);
      end
    end

    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[remote_frame_decoder] OK");
    end else begin
      $display("[remote_frame_decoder] ERROR");
    end
    $finish;
  end

endmodule

[remote_frame_decoder.f]
rtl/rfd_pkg.sv
rtl/rfd_decode.sv
rtl/remote_frame_decoder.sv
rtl/rfd_checker.sv
tb/remote_frame_decoder_tb.sv
